FILE: rtl/core/sil_pkg.sv
// ----------------------------------------------------------------------------
// sil_pkg
// Shared codes and types of the shader instruction lowering block: input
// instruction kinds, encoding formats, lowered operation kinds, failure
// reasons, operand classes and the layout of one lowered operation.
// ----------------------------------------------------------------------------
package sil_pkg;

  // Decoded instruction kinds on the input side.
  localparam logic [4:0] ACT_NOP          = 5'd0;
  localparam logic [4:0] ACT_ENDPGM       = 5'd1;
  localparam logic [4:0] ACT_BRANCH       = 5'd2;
  localparam logic [4:0] ACT_CBR_SCC0     = 5'd3;
  localparam logic [4:0] ACT_CBR_EXECNZ   = 5'd8;
  localparam logic [4:0] ACT_BARRIER      = 5'd9;
  localparam logic [4:0] ACT_WAITCNT      = 5'd10;
  localparam logic [4:0] ACT_SMOV32       = 5'd11;
  localparam logic [4:0] ACT_SMOV64       = 5'd12;
  localparam logic [4:0] ACT_VMOV32       = 5'd13;
  localparam logic [4:0] ACT_VADD         = 5'd14;
  localparam logic [4:0] ACT_EXPORT       = 5'd15;
  localparam logic [4:0] ACT_UNK_SOPP     = 5'd16;
  localparam logic [4:0] ACT_UNK_SOP1     = 5'd17;
  localparam logic [4:0] ACT_UNK_VOP1     = 5'd18;
  localparam logic [4:0] ACT_UNK_VOP2     = 5'd19;
  localparam logic [4:0] ACT_UNSUP_ENC    = 5'd20;

  // Encoding formats.
  localparam logic [2:0] FMT_SOPP  = 3'd0;
  localparam logic [2:0] FMT_SOP1  = 3'd1;
  localparam logic [2:0] FMT_VOP1  = 3'd2;
  localparam logic [2:0] FMT_VOP2  = 3'd3;
  localparam logic [2:0] FMT_EXP   = 3'd4;
  localparam logic [2:0] FMT_UNSUP = 3'd5;

  // Bit of the present-payload mask that flags a trailing literal.
  localparam int unsigned LIT_PRESENT_BIT = 5;

  // Scalar selector ranges.
  localparam logic [7:0] SGPR_LAST        = 8'd105;
  localparam logic [7:0] SGPR_PAIR_LAST   = 8'd104;
  localparam logic [7:0] VCC_LO_SEL       = 8'd106;
  localparam logic [7:0] VCC_HI_SEL       = 8'd107;
  localparam logic [7:0] M0_SEL           = 8'd124;
  localparam logic [7:0] NULL_SEL         = 8'd125;
  localparam logic [7:0] EXEC_LO_SEL      = 8'd126;
  localparam logic [7:0] EXEC_HI_SEL      = 8'd127;
  localparam logic [7:0] INLINE_POS_FIRST = 8'd128;
  localparam logic [7:0] INLINE_POS_LAST  = 8'd192;
  localparam logic [7:0] INLINE_NEG_FIRST = 8'd193;
  localparam logic [7:0] INLINE_NEG_LAST  = 8'd208;
  localparam logic [7:0] LITERAL_SEL      = 8'd255;

  // Export target code ranges.
  localparam logic [5:0] TGT_MRT_LAST    = 6'h07;
  localparam logic [5:0] TGT_MRTZ        = 6'h08;
  localparam logic [5:0] TGT_NULL        = 6'h09;
  localparam logic [5:0] TGT_POS_FIRST   = 6'h0c;
  localparam logic [5:0] TGT_POS_LAST    = 6'h0f;
  localparam logic [5:0] TGT_PRIM        = 6'h14;
  localparam logic [5:0] TGT_PARAM_FIRST = 6'h20;
  localparam logic [5:0] TGT_PARAM_LAST  = 6'h3f;

  // Lowered operation kinds.
  typedef enum logic [3:0] {
    OP_NOP     = 4'd0,
    OP_END     = 4'd1,
    OP_BRANCH  = 4'd2,
    OP_CBRANCH = 4'd3,
    OP_BARRIER = 4'd4,
    OP_WAIT    = 4'd5,
    OP_SMOV32  = 4'd6,
    OP_SMOV64  = 4'd7,
    OP_VMOV32  = 4'd8,
    OP_VADD    = 4'd9,
    OP_EXPORT  = 4'd10,
    OP_UNSUP   = 4'd11
  } op_kind_t;

  // Reasons carried with an unsupported operation.
  typedef enum logic [3:0] {
    FAIL_INVALID   = 4'd0,
    FAIL_SCALAR    = 4'd1,
    FAIL_VECTOR    = 4'd2,
    FAIL_EXP_TGT   = 4'd3,
    FAIL_UNK_SOPP  = 4'd4,
    FAIL_UNK_SOP1  = 4'd5,
    FAIL_UNK_VOP1  = 4'd6,
    FAIL_UNK_VOP2  = 4'd7,
    FAIL_ENCODING  = 4'd8
  } fail_reason_t;

  // Scalar source classes.
  localparam logic [3:0] SCLS_SGPR    = 4'd0;
  localparam logic [3:0] SCLS_VCC_LO  = 4'd1;
  localparam logic [3:0] SCLS_VCC_HI  = 4'd2;
  localparam logic [3:0] SCLS_M0      = 4'd3;
  localparam logic [3:0] SCLS_NULL    = 4'd4;
  localparam logic [3:0] SCLS_EXEC_LO = 4'd5;
  localparam logic [3:0] SCLS_EXEC_HI = 4'd6;
  localparam logic [3:0] SCLS_INLINE  = 4'd7;
  localparam logic [3:0] SCLS_LITERAL = 4'd8;

  // Export target classes.
  localparam logic [3:0] ECLS_MRT   = 4'd0;
  localparam logic [3:0] ECLS_MRTZ  = 4'd1;
  localparam logic [3:0] ECLS_NULL  = 4'd2;
  localparam logic [3:0] ECLS_POS   = 4'd3;
  localparam logic [3:0] ECLS_PRIM  = 4'd4;
  localparam logic [3:0] ECLS_PARAM = 4'd5;

  // Widths of the stream payloads.
  localparam int unsigned IN_DATA_W  = 128;
  localparam int unsigned IN_USER_W  = 8;
  localparam int unsigned OUT_DATA_W = 136;
  localparam int unsigned OUT_USER_W = 4;

  // One lowered operation.
  typedef struct packed {
    op_kind_t     op_kind;
    fail_reason_t fail_reason;
    logic [3:0]   sub_kind;
    logic [18:0]  branch_offset;
    logic [14:0]  wait_counts;
    logic [4:0]   nop_repeats;
    logic [7:0]   dest_index;
    logic [31:0]  source_value;
    logic [7:0]   source1_index;
    logic [6:0]   export_flags;
    logic [31:0]  export_regs;
  } lowered_op_t;

endpackage

FILE: rtl/core/shader_instruction_lowering.sv
// ----------------------------------------------------------------------------
// shader_instruction_lowering
// Lowers one decoded shader instruction into one operation: checks format and
// payload mask against the kind, then decodes the operands or gives a reason.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: action, encoding_format; tdata: instruction fields
//  m_axis    out        tuser: op_kind; tdata: lowered operation fields
//
//  Each transaction passes an input register and then a result register;
//  m_axis presents the result register. One transaction is accepted every
//  cycle unless a stall holds both registers full; the only logic between
//  the two registers is the lowering decode.
//  A stall on m_axis holds the result register, and the input register once it
//  is full; s_axis tready drops only when both registers are full and the
//  result is not taken.
//  rst is synchronous and clears both valid flags; payloads are not reset.
//
module shader_instruction_lowering (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata, from bit 0: payload_present[5:0], instr_words[7:6],
  // immediate16[23:8], dest_select[31:24], src0_select[40:32],
  // src1_select[48:41], literal_word[80:49], export_target_code[86:81],
  // export_control[93:87], export_sources[125:94], zero fill[127:126]
  input  logic [sil_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser, from bit 0: action[4:0], encoding_format[7:5]
  input  logic [sil_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata, from bit 0: fail_reason[3:0], sub_kind[7:4], branch_offset[26:8],
  // wait_counts[41:27], nop_repeats[46:42], dest_index[54:47],
  // source_value[86:55], source1_index[94:87], export_flags[101:95],
  // export_regs[133:102], zero fill[135:134]
  output logic [sil_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser, from bit 0: op_kind[3:0]
  output logic [sil_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

  // Input register and result register.
  logic                          in_valid;
  logic [sil_pkg::IN_DATA_W-1:0] in_data;
  logic [sil_pkg::IN_USER_W-1:0] in_user;
  logic                          out_valid;
  sil_pkg::lowered_op_t          out_op;
  sil_pkg::lowered_op_t          out_op_next;
  logic                          advance;

  // Fields of the registered instruction.
  logic [4:0]  action;
  logic [2:0]  fmt;
  logic [5:0]  mask;
  logic [1:0]  words;
  logic [15:0] imm;
  logic [7:0]  dst;
  logic [8:0]  src0;
  logic [7:0]  src1;
  logic [31:0] lit;
  logic [5:0]  tgt;
  logic [6:0]  ctl;
  logic [31:0] srcs;

  assign action = in_user[4:0];
  assign fmt    = in_user[7:5];
  assign mask   = in_data[5:0];
  assign words  = in_data[7:6];
  assign imm    = in_data[23:8];
  assign dst    = in_data[31:24];
  assign src0   = in_data[40:32];
  assign src1   = in_data[48:41];
  assign lit    = in_data[80:49];
  assign tgt    = in_data[86:81];
  assign ctl    = in_data[93:87];
  assign srcs   = in_data[125:94];

  // Format and payload mask checks: the format's own bit alone among bits 4:0, none for the unsupported encoding.
  logic sopp_ok;
  logic sop1_ok;
  logic vop1_ok;
  logic vop2_ok;
  logic exp_ok;
  logic unsup_enc_ok;

  assign sopp_ok = (fmt == sil_pkg::FMT_SOPP) && (mask[4:0] == 5'b00001);
  assign sop1_ok = (fmt == sil_pkg::FMT_SOP1) && (mask[4:0] == 5'b00010);
  assign vop1_ok = (fmt == sil_pkg::FMT_VOP1) && (mask[4:0] == 5'b00100);
  assign vop2_ok = (fmt == sil_pkg::FMT_VOP2) && (mask[4:0] == 5'b01000);
  assign exp_ok  = (fmt == sil_pkg::FMT_EXP) && (mask[4:0] == 5'b10000) &&
                   (words == 2'd2);
  assign unsup_enc_ok = (fmt == sil_pkg::FMT_UNSUP) && (mask[4:0] == 5'b00000);

  // Scalar source classification of src0.
  logic        scls_ok;
  logic [3:0]  scls;
  logic [31:0] sval;

  always_comb begin
    scls_ok = 1'b1;
    scls    = sil_pkg::SCLS_SGPR;
    sval    = 32'd0;
    if (src0[8]) begin
      scls_ok = 1'b0;
    end else if (src0[7:0] <= sil_pkg::SGPR_LAST) begin
      sval = {24'd0, src0[7:0]};
    end else if (src0[7:0] == sil_pkg::VCC_LO_SEL) begin
      scls = sil_pkg::SCLS_VCC_LO;
    end else if (src0[7:0] == sil_pkg::VCC_HI_SEL) begin
      scls = sil_pkg::SCLS_VCC_HI;
    end else if (src0[7:0] == sil_pkg::M0_SEL) begin
      scls = sil_pkg::SCLS_M0;
    end else if (src0[7:0] == sil_pkg::NULL_SEL) begin
      scls = sil_pkg::SCLS_NULL;
    end else if (src0[7:0] == sil_pkg::EXEC_LO_SEL) begin
      scls = sil_pkg::SCLS_EXEC_LO;
    end else if (src0[7:0] == sil_pkg::EXEC_HI_SEL) begin
      scls = sil_pkg::SCLS_EXEC_HI;
    end else if ((src0[7:0] >= sil_pkg::INLINE_POS_FIRST) &&
                 (src0[7:0] <= sil_pkg::INLINE_POS_LAST)) begin
      scls = sil_pkg::SCLS_INLINE;
      sval = {24'd0, src0[7:0] - sil_pkg::INLINE_POS_FIRST};
    end else if ((src0[7:0] >= sil_pkg::INLINE_NEG_FIRST) &&
                 (src0[7:0] <= sil_pkg::INLINE_NEG_LAST)) begin
      // Negative inline integers count down from -1.
      scls = sil_pkg::SCLS_INLINE;
      sval = {24'd0, sil_pkg::INLINE_POS_LAST} - {24'd0, src0[7:0]};
    end else if ((src0[7:0] == sil_pkg::LITERAL_SEL) &&
                 mask[sil_pkg::LIT_PRESENT_BIT]) begin
      scls = sil_pkg::SCLS_LITERAL;
      sval = lit;
    end else begin
      scls_ok = 1'b0;
    end
  end

  // Export target classification.
  logic       ecls_ok;
  logic [3:0] ecls;
  logic [7:0] eidx;

  always_comb begin
    ecls_ok = 1'b1;
    ecls    = sil_pkg::ECLS_MRT;
    eidx    = 8'd0;
    if (tgt <= sil_pkg::TGT_MRT_LAST) begin
      eidx = {5'd0, tgt[2:0]};
    end else if (tgt == sil_pkg::TGT_MRTZ) begin
      ecls = sil_pkg::ECLS_MRTZ;
    end else if (tgt == sil_pkg::TGT_NULL) begin
      ecls = sil_pkg::ECLS_NULL;
    end else if ((tgt >= sil_pkg::TGT_POS_FIRST) && (tgt <= sil_pkg::TGT_POS_LAST)) begin
      ecls = sil_pkg::ECLS_POS;
      eidx = {2'd0, tgt - sil_pkg::TGT_POS_FIRST};
    end else if (tgt == sil_pkg::TGT_PRIM) begin
      ecls = sil_pkg::ECLS_PRIM;
    end else if ((tgt >= sil_pkg::TGT_PARAM_FIRST) &&
                 (tgt <= sil_pkg::TGT_PARAM_LAST)) begin
      ecls = sil_pkg::ECLS_PARAM;
      eidx = {2'd0, tgt - sil_pkg::TGT_PARAM_FIRST};
    end else begin
      ecls_ok = 1'b0;
    end
  end

  // Register pair checks for the 64-bit scalar move.
  logic dst_pair_ok;
  logic src_pair_ok;

  assign dst_pair_ok = (dst <= sil_pkg::SGPR_PAIR_LAST) && !dst[0];
  assign src_pair_ok = !src0[8] && (src0[7:0] <= sil_pkg::SGPR_PAIR_LAST) && !src0[0];

  // Lowering decode: unsupported and invalid unless a kind's format check passes.
  always_comb begin
    out_op_next         = '0;
    out_op_next.op_kind = sil_pkg::OP_UNSUP;
    case (action)
      sil_pkg::ACT_NOP: begin
        if (sopp_ok) begin
          out_op_next.op_kind     = sil_pkg::OP_NOP;
          out_op_next.nop_repeats = {1'b0, imm[3:0]} + 5'd1;
        end
      end
      sil_pkg::ACT_ENDPGM: begin
        if (sopp_ok) begin
          out_op_next.op_kind = sil_pkg::OP_END;
        end
      end
      sil_pkg::ACT_BARRIER: begin
        if (sopp_ok) begin
          out_op_next.op_kind = sil_pkg::OP_BARRIER;
        end
      end
      sil_pkg::ACT_WAITCNT: begin
        if (sopp_ok) begin
          out_op_next.op_kind     = sil_pkg::OP_WAIT;
          out_op_next.wait_counts = {imm[15:14], imm[3:0], imm[13:8], imm[6:4]};
        end
      end
      sil_pkg::ACT_SMOV32: begin
        if (sop1_ok) begin
          if ((dst <= sil_pkg::SGPR_LAST) && scls_ok) begin
            out_op_next.op_kind      = sil_pkg::OP_SMOV32;
            out_op_next.sub_kind     = scls;
            out_op_next.dest_index   = dst;
            out_op_next.source_value = sval;
          end else begin
            out_op_next.fail_reason = sil_pkg::FAIL_SCALAR;
          end
        end
      end
      sil_pkg::ACT_SMOV64: begin
        if (sop1_ok) begin
          if (dst_pair_ok && src_pair_ok) begin
            out_op_next.op_kind      = sil_pkg::OP_SMOV64;
            out_op_next.dest_index   = dst;
            out_op_next.source_value = {24'd0, src0[7:0]};
          end else begin
            out_op_next.fail_reason = sil_pkg::FAIL_SCALAR;
          end
        end
      end
      sil_pkg::ACT_VMOV32, sil_pkg::ACT_VADD: begin
        if ((action == sil_pkg::ACT_VMOV32) ? vop1_ok : vop2_ok) begin
          if (src0[8]) begin
            out_op_next.op_kind      = (action == sil_pkg::ACT_VMOV32) ?
                                       sil_pkg::OP_VMOV32 : sil_pkg::OP_VADD;
            out_op_next.dest_index   = dst;
            out_op_next.source_value = {24'd0, src0[7:0]};
            if (action == sil_pkg::ACT_VADD) begin
              out_op_next.source1_index = src1;
            end
          end else begin
            out_op_next.fail_reason = sil_pkg::FAIL_VECTOR;
          end
        end
      end
      sil_pkg::ACT_EXPORT: begin
        if (exp_ok) begin
          if (ecls_ok) begin
            out_op_next.op_kind      = sil_pkg::OP_EXPORT;
            out_op_next.sub_kind     = ecls;
            out_op_next.dest_index   = eidx;
            out_op_next.export_flags = ctl;
            out_op_next.export_regs  = srcs;
          end else begin
            out_op_next.fail_reason = sil_pkg::FAIL_EXP_TGT;
          end
        end
      end
      sil_pkg::ACT_UNK_SOPP: begin
        if (sopp_ok) out_op_next.fail_reason = sil_pkg::FAIL_UNK_SOPP;
      end
      sil_pkg::ACT_UNK_SOP1: begin
        if (sop1_ok) out_op_next.fail_reason = sil_pkg::FAIL_UNK_SOP1;
      end
      sil_pkg::ACT_UNK_VOP1: begin
        if (vop1_ok) out_op_next.fail_reason = sil_pkg::FAIL_UNK_VOP1;
      end
      sil_pkg::ACT_UNK_VOP2: begin
        if (vop2_ok) out_op_next.fail_reason = sil_pkg::FAIL_UNK_VOP2;
      end
      sil_pkg::ACT_UNSUP_ENC: begin
        if (unsup_enc_ok) out_op_next.fail_reason = sil_pkg::FAIL_ENCODING;
      end
      default: begin
        // Codes 2 to 8 are branches, plain or conditional; others are invalid.
        if ((action >= sil_pkg::ACT_BRANCH) && (action <= sil_pkg::ACT_CBR_EXECNZ) &&
            sopp_ok) begin
          out_op_next.op_kind       = (action == sil_pkg::ACT_BRANCH) ?
                                      sil_pkg::OP_BRANCH : sil_pkg::OP_CBRANCH;
          out_op_next.sub_kind      = (action == sil_pkg::ACT_BRANCH) ? 4'd0 :
                                      4'(action - sil_pkg::ACT_CBR_SCC0);
          out_op_next.branch_offset = {imm[15], imm, 2'b00} + 19'd4;
        end
      end
    endcase
  end

  // Handshake: the result register moves unless held; an empty input register loads.
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (advance) out_valid <= in_valid;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data <= s_axis_tdata;
      in_user <= s_axis_tuser;
    end
    if (advance && in_valid) begin
      out_op <= out_op_next;
    end
  end

  // Output packing.
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_op.op_kind;
  assign m_axis_tdata  = {2'b00,
                          out_op.export_regs,
                          out_op.export_flags,
                          out_op.source1_index,
                          out_op.source_value,
                          out_op.dest_index,
                          out_op.nop_repeats,
                          out_op.wait_counts,
                          out_op.branch_offset,
                          out_op.sub_kind,
                          out_op.fail_reason};

`ifndef SYNTHESIS
  // An accepted transaction always fills the input register.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> in_valid)
    else $error("accepted transaction did not reach the input register");

  // A held result keeps the input register from being overwritten.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while both registers are full and stalled");

  // Only unsupported operations carry a failure reason.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (out_op.op_kind != sil_pkg::OP_UNSUP)) |->
      (out_op.fail_reason == sil_pkg::FAIL_INVALID))
    else $error("failure reason on a supported operation");

  // A nop always repeats at least once.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (out_op.op_kind == sil_pkg::OP_NOP)) |->
      (out_op.nop_repeats != 5'd0))
    else $error("nop with zero repeat count");

  // Export fields appear only on an export.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (out_op.op_kind != sil_pkg::OP_EXPORT)) |->
      ((out_op.export_flags == 7'd0) && (out_op.export_regs == 32'd0)))
    else $error("export fields set on a non-export operation");
`endif

endmodule
